@@ hw/rtl/deque_with_delete_all_extreme_unit_assert.svh @@
// Assertion macros for the deque unit.
`ifndef DEQUE_WITH_DELETE_ALL_EXTREME_UNIT_ASSERT_SVH
`define DEQUE_WITH_DELETE_ALL_EXTREME_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define DQDX_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque unit: implication failed");

// Next-cycle implication, off while reset is asserted.
`define DQDX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque unit: next-cycle check failed");

`endif

@@ hw/rtl/dqdx_pkg.sv @@
// Shared types and codes for the deque unit.
package dqdx_pkg;

    localparam int unsigned DATA_W = 32;

    // Operation codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DEL_MAX    = 3'd4,
        OP_DEL_MIN    = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMPACT,
        S_DONE
    } t_state;

    // Where a cell takes its next value from
    typedef enum logic [1:0] {
        CM_HOLD,
        CM_FROM_LEFT,
        CM_FROM_RIGHT
    } t_cell_mode;

    // Command broadcast to every cell of the row
    typedef struct packed {
        t_cell_mode               mode;
        logic                     load_en;
        logic signed [DATA_W-1:0] load_data;
    } t_cell_cmd;

endpackage

@@ hw/rtl/dqdx_cell.sv @@
// One storage cell of the deque row: holds an entry and shifts with its neighbors.
module dqdx_cell
    import dqdx_pkg::*;
#(
    parameter int unsigned IDX_W = 4,
    parameter int unsigned IDX   = 0
) (
    input  logic                     i_clk,
    input  t_cell_cmd                i_cmd,
    input  logic [IDX_W-1:0]         i_load_idx,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_q
);

    logic signed [DATA_W-1:0] r_q;
    logic signed [DATA_W-1:0] n_q;
    logic                     w_hit;

    assign w_hit = i_cmd.load_en && (i_load_idx == IDX_W'(IDX));

    // Addressed load wins over the shift
    always_comb begin
        n_q = r_q;
        if (w_hit) begin
            n_q = i_cmd.load_data;
        end else begin
            case (i_cmd.mode)
                CM_FROM_LEFT:  n_q = i_left;
                CM_FROM_RIGHT: n_q = i_right;
                default:       n_q = r_q;
            endcase
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ hw/rtl/deque_with_delete_all_extreme_unit.sv @@
// Top level of the deque unit: controller over a row of storage cells.
// Bounded double-ended queue of signed 32-bit values, up to DEPTH entries, kept as a row of
// cells with the front entry always in cell 0. For push, pop, unknown operation codes and a
// delete on an empty deque, the input transfer and the result are registered at the same edge.
// Delete-all-max and delete-all-min on N held entries rotate the row one position per cycle,
// first over the N entries to find the extreme at cell 0, then over them again to rebuild the
// row without the matching entries, then post the result once the output register is free.
// The input is stalled while a delete runs and while an unread result blocks a new one.
module deque_with_delete_all_extreme_unit
    import dqdx_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [2:0]                         i_operation,
    input  logic signed [DATA_W-1:0]           i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic [$clog2(DEPTH+1)-1:0]         o_count_after,
    output logic [$clog2(DEPTH+1)-1:0]         o_removed
);

`include "deque_with_delete_all_extreme_unit_assert.svh"

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH+1);

    // Control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_step, n_step;
    logic               r_want_max, n_want_max;
    logic signed [DATA_W-1:0] r_best, n_best;
    logic               r_out_valid, n_out_valid;

    // Result payload
    t_status            r_status, n_status;
    logic [CNT_W-1:0]   r_cnt_out, n_cnt_out;
    logic [CNT_W-1:0]   r_rem_out, n_rem_out;

    // Cell row
    t_cell_cmd                w_cmd;
    logic [IDX_W-1:0]         w_load_idx;
    logic signed [DATA_W-1:0] w_cell_q [DEPTH];
    logic signed [DATA_W-1:0] w_head;

    logic w_out_free;
    logic w_accept;
    logic w_last_step;
    logic w_keep;

    assign w_head      = w_cell_q[0];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_last_step = (CNT_W'(r_step + 1'b1) == r_n);
    assign w_keep      = (w_head != r_best);

    // Row of cells; cell 0 takes the pushed value from the left, the last wraps to cell 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_cell_q[g-1];
        end
        if (g == DEPTH-1) begin : g_last
            assign w_right = w_cell_q[0];
        end else begin : g_mid_r
            assign w_right = w_cell_q[g+1];
        end
        dqdx_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_load_idx (w_load_idx),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_q        (w_cell_q[g])
        );
    end

    // Next state, cell commands and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_n         = r_n;
        n_step      = r_step;
        n_want_max  = r_want_max;
        n_best      = r_best;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_cnt_out   = r_cnt_out;
        n_rem_out   = r_rem_out;
        w_cmd.mode      = CM_HOLD;
        w_cmd.load_en   = 1'b0;
        w_cmd.load_data = i_value;
        w_load_idx      = r_count[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_rem_out   = '0;
                    case (i_operation)
                        OP_PUSH_FRONT: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.mode = CM_FROM_LEFT;
                                n_count    = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.load_en = 1'b1;
                                n_count       = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_cmd.mode = CM_FROM_RIGHT;
                                n_count    = r_count - 1'b1;
                                n_rem_out  = CNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count   = r_count - 1'b1;
                                n_rem_out = CNT_W'(1);
                            end
                        end
                        OP_DEL_MAX, OP_DEL_MIN: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // No result yet: run the scan
                                n_out_valid = r_out_valid && i_out_stall;
                                n_state     = S_SCAN;
                                n_want_max  = (i_operation == OP_DEL_MAX);
                                n_n         = r_count;
                                n_len       = r_count;
                                n_step      = '0;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                    n_cnt_out = n_count;
                end
            end

            // Rotate the occupied part once, tracking the extreme at cell 0
            S_SCAN: begin
                w_cmd.mode      = CM_FROM_RIGHT;
                w_cmd.load_en   = 1'b1;
                w_cmd.load_data = w_head;
                w_load_idx      = IDX_W'(r_n - 1'b1);
                if (r_step == '0) begin
                    n_best = w_head;
                end else if (r_want_max ? (w_head > r_best) : (w_head < r_best)) begin
                    n_best = w_head;
                end
                n_step = r_step + 1'b1;
                if (w_last_step) begin
                    n_state = S_COMPACT;
                    n_step  = '0;
                end
            end

            // Take the head off; put it back at the tail only if it is kept
            S_COMPACT: begin
                w_cmd.mode      = CM_FROM_RIGHT;
                w_cmd.load_en   = w_keep;
                w_cmd.load_data = w_head;
                w_load_idx      = IDX_W'(r_len - 1'b1);
                if (!w_keep) begin
                    n_len = r_len - 1'b1;
                end
                n_step = r_step + 1'b1;
                if (w_last_step) begin
                    n_state = S_DONE;
                end
            end

            // Post the delete result once the output register is free
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_count     = r_len;
                    n_cnt_out   = r_len;
                    n_rem_out   = r_n - r_len;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_n        <= n_n;
        r_step     <= n_step;
        r_want_max <= n_want_max;
        r_best     <= n_best;
        r_status   <= n_status;
        r_cnt_out  <= n_cnt_out;
        r_rem_out  <= n_rem_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_count_after = r_cnt_out;
    assign o_removed     = r_rem_out;

    // Checks
    `DQDX_ASSERT_IMPLY(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_in_stall)
    `DQDX_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `DQDX_ASSERT_IMPLY(a_len_bound, i_clk, i_rst_n, r_state == S_COMPACT || r_state == S_DONE,
        r_len <= r_n)
    `DQDX_ASSERT_NEXT(a_full_flag, i_clk, i_rst_n,
        w_accept && (i_operation == OP_PUSH_FRONT || i_operation == OP_PUSH_BACK)
        && (r_count == CNT_W'(DEPTH)), o_out_valid && (o_status == ST_FULL))

endmodule
